@@ hdl/pcpa_pkg.sv @@
// Shared constants, types and codes for the per-CPU page allocator.
`default_nettype none

package pcpa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 32;
  localparam int CPU_W      = 3;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;   // page number width
  localparam int SLOT_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = SLOT_W + 1;            // top bit marks end of list
  localparam int ALU_W      = ADDR_W;

  localparam int IN_DATA_W  = 40;   // cpu + page_address, padded to bytes
  localparam int OUT_DATA_W = 40;   // status + granted_address + source_cpu

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_NO_MEM   = 2'd2
  } status_t;

  typedef enum logic {
    FN_FREE  = 1'b0,
    FN_ALLOC = 1'b1
  } func_t;

  typedef enum logic {
    REG_LOWEST = 1'b0,
    REG_TOP    = 1'b1
  } cfg_reg_t;

  // one operation for the shared adder
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
    logic             cin;
  } alu_req_t;

endpackage

`default_nettype wire

@@ hdl/per_cpu_page_allocator.sv @@
// Per-CPU LIFO page allocator with stealing: sequencer, heads and result register.
//
// Requests arrive as beats on the s_ channel: s_tuser is the function (free or
// allocate), s_tdata the CPU number and the page address. Each request gives
// one result beat on the m_ channel: status, granted address and source CPU.
// Configuration (lowest and top address) is written on the cfg_ channel, which
// is always ready; write it only while no request is in flight.
// A request walks a small sequencer around one shared 33-bit adder:
//   free     : base round-up, low compare, top compare, slot offset, push
//              -> result registered after the push; earlier when the
//              address window rejects it or the slot is past the last page.
//   allocate : base round-up, list pick, synchronous link read, address add
//              -> result registered after the address add, earlier when out of memory.
// s_tready is high only while the sequencer is idle, so one request is in flight
// at a time; the next request is taken in the cycle after the result load at the
// earliest. If m_tready stays low, a finished result waits in the sequencer until
// the output register frees up. Reset empties every list and loads the default
// address window; link memory contents are never cleared.
`default_nettype none

module per_cpu_page_allocator
  import pcpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request: tdata = cpu[2:0], page_address[34:3]; tuser = func[0]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  // result: tdata = status[1:0], granted_address[33:2], source_cpu[36:34]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_BASE = 9'b000000010,
    S_LO   = 9'b000000100,
    S_HI   = 9'b000001000,
    S_SLOT = 9'b000010000,
    S_PUSH = 9'b000100000,
    S_PICK = 9'b001000000,
    S_LINK = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [ADDR_W-1:0] lowest_address;
  logic [ADDR_W-1:0] top_address;

  logic [NUM_CPUS-1:0] head_valid;
  logic [SLOT_W-1:0]   head_slot [NUM_CPUS];

  logic              op_alloc;
  logic [CPU_W-1:0]  me;
  logic [ADDR_W-1:0] addr;
  logic [PG_W:0]     base_pg;
  logic              lo_ok;
  logic [CPU_W-1:0]  src;
  logic [SLOT_W-1:0] slot;
  status_t           res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [CPU_W-1:0]  res_src;

  alu_req_t       alu_req;
  logic [ALU_W:0] alu_sum;

  logic              found;
  logic [CPU_W-1:0]  found_cpu;

  logic              wr_en;
  logic              rd_en;
  logic [LINK_W-1:0] wr_data;
  logic [LINK_W-1:0] rd_data;

  logic out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  pcpa_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  pcpa_link_mem u_link_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head_slot[found_cpu]),
    .rd_data (rd_data)
  );

  // own list first, else the lowest-numbered other non-empty list
  always_comb begin
    found     = head_valid[me];
    found_cpu = me;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (!found && head_valid[i]) begin
        found     = 1'b1;
        found_cpu = CPU_W'(i);
      end
    end
  end

  assign wr_en   = (state == S_PUSH);
  assign wr_data = {!head_valid[me], head_slot[me]};
  assign rd_en   = (state == S_PICK);

  // operand select for the shared adder
  always_comb begin
    alu_req = '0;
    case (state)
      S_BASE: begin
        alu_req.a   = ALU_W'(lowest_address[ADDR_W-1:PAGE_SHIFT]);
        alu_req.cin = |lowest_address[PAGE_SHIFT-1:0];
      end
      S_LO: begin
        alu_req.a   = addr;
        alu_req.b   = lowest_address;
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      S_HI: begin
        alu_req.a   = addr;
        alu_req.b   = top_address;
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      S_SLOT: begin
        alu_req.a   = ALU_W'(addr[ADDR_W-1:PAGE_SHIFT]);
        alu_req.b   = ALU_W'(base_pg);
        alu_req.sub = 1'b1;
        alu_req.cin = 1'b1;
      end
      S_LINK: begin
        alu_req.a = ALU_W'(base_pg);
        alu_req.b = ALU_W'(slot);
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_BASE;
      S_BASE: state_next = op_alloc ? S_PICK : S_LO;
      S_LO:   state_next = S_HI;
      S_HI:   state_next = (lo_ok && !alu_sum[ALU_W]) ? S_SLOT : S_DONE;
      S_SLOT: state_next = (alu_sum[ALU_W-1:SLOT_W] == '0) ? S_PUSH : S_DONE;
      S_PUSH: state_next = S_DONE;
      S_PICK: state_next = found ? S_LINK : S_DONE;
      S_LINK: state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_address <= 32'h8000_0000;
      top_address    <= 32'h8800_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWEST: lowest_address <= cfg_data;
        REG_TOP:    top_address    <= cfg_data;
        default:    lowest_address <= lowest_address;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
    end else if (state == S_PUSH) begin
      head_valid[me] <= 1'b1;
    end else if (state == S_LINK) begin
      head_valid[src] <= !rd_data[SLOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      head_slot[me] <= slot;
    end else if (state == S_LINK) begin
      head_slot[src] <= rd_data[SLOT_W-1:0];
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_alloc   <= (func_t'(s_tuser[0]) == FN_ALLOC);
        me         <= s_tdata[CPU_W-1:0];
        addr       <= s_tdata[CPU_W +: ADDR_W];
        res_status <= ST_OK;
        res_addr   <= '0;
        res_src    <= '0;
      end
      S_BASE: base_pg <= alu_sum[PG_W:0];
      S_LO:   lo_ok   <= alu_sum[ALU_W] && (addr[PAGE_SHIFT-1:0] == '0);
      S_HI: begin
        if (!(lo_ok && !alu_sum[ALU_W])) res_status <= ST_BAD_ADDR;
      end
      S_SLOT: begin
        slot <= alu_sum[SLOT_W-1:0];
        if (alu_sum[ALU_W-1:SLOT_W] != '0) res_status <= ST_BAD_ADDR;
      end
      S_PICK: begin
        src  <= found_cpu;
        slot <= head_slot[found_cpu];
        if (!found) res_status <= ST_NO_MEM;
      end
      S_LINK: begin
        res_addr <= {alu_sum[PG_W-1:0], {PAGE_SHIFT{1'b0}}};
        res_src  <= src;
      end
      default: res_status <= res_status;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'({res_src, res_addr, res_status});
    end
  end

endmodule

`default_nettype wire

@@ hdl/pcpa_alu.sv @@
// Shared add/subtract unit used for every address compare and offset.
`default_nettype none

module pcpa_alu
  import pcpa_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W:0]   sum
);

  logic [ALU_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  // carry out of a subtract is set when a >= b
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.cin};

endmodule

`default_nettype wire

@@ hdl/pcpa_link_mem.sv @@
// Next-link memory, one entry per page slot, registered read.
`default_nettype none

module pcpa_link_mem
  import pcpa_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  logic [LINK_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ bench/pcpa_checker.sv @@
// Scoreboard for the page allocator: mirrors the per-CPU free lists and checks each result beat.
module pcpa_checker
  import pcpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  output int                    n_req,
  output int                    n_res,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] END_OF_LIST = 16'hFFFF;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
    logic [CPU_W-1:0]    src;
  } grant_t;

  logic [15:0]       head_slot [NUM_CPUS];
  logic [15:0]       next_slot [NUM_PAGES];
  logic [ADDR_W-1:0] win_low;
  logic [ADDR_W-1:0] win_top;
  grant_t            grants_due [$];

  // Applies one request to the mirrored lists and returns the result it must produce.
  function automatic grant_t serve_request(func_t fn, logic [CPU_W-1:0] cpu,
                                           logic [ADDR_W-1:0] addr);
    grant_t          g;
    longint unsigned base;
    longint unsigned a;
    longint unsigned slot;
    int              me;
    int              src;
    int              i;
    bit              found;
    g.status = ST_OK;
    g.addr   = '0;
    g.src    = '0;
    base = 64'(win_low);
    base = ((base + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    a    = 64'(addr);
    me   = cpu % NUM_CPUS;
    if (fn == FN_FREE) begin
      if ((a % PAGE_BYTES) != 0 || a < win_low || a >= win_top || a < base) begin
        g.status = ST_BAD_ADDR;
      end else begin
        slot = (a - base) / PAGE_BYTES;
        if (slot >= NUM_PAGES) begin
          g.status = ST_BAD_ADDR;
        end else begin
          next_slot[slot] = head_slot[me];
          head_slot[me]   = slot[15:0];
        end
      end
    end else begin
      src   = me;
      found = (head_slot[me] != END_OF_LIST);
      // steal from the lowest-numbered other list that has a page
      for (i = 0; i < NUM_CPUS; i++) begin
        if (!found && i != me && head_slot[i] != END_OF_LIST) begin
          src   = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        g.status = ST_NO_MEM;
      end else begin
        slot           = 64'(head_slot[src]);
        head_slot[src] = next_slot[slot];
        a              = base + slot * PAGE_BYTES;
        g.addr         = a[ADDR_W-1:0];
        g.src          = src[CPU_W-1:0];
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst) begin
      win_low = 32'h8000_0000;
      win_top = 32'h8800_0000;
      foreach (head_slot[i]) head_slot[i] = END_OF_LIST;
      grants_due.delete();
      errors = 0;
      n_req <= 0;
      n_res <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_reg_t'(cfg_index) == REG_LOWEST) win_low = cfg_data;
        else win_top = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[1:0]);
        got.addr   = m_tdata[2 +: ADDR_W];
        got.src    = m_tdata[2 + ADDR_W +: CPU_W];
        n_res <= n_res + 1;
        if (grants_due.size() == 0) begin
          $display("%0t: result beat with no request outstanding: expected none, actual %h",
                   $time, m_tdata);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.addr !== want.addr) begin
            $display("%0t: granted_address mismatch: expected %h, actual %h",
                     $time, want.addr, got.addr);
            errors++;
          end
          if (got.src !== want.src) begin
            $display("%0t: source_cpu mismatch: expected %0d, actual %0d",
                     $time, want.src, got.src);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        grants_due.push_back(serve_request(func_t'(s_tuser), s_tdata[CPU_W-1:0],
                                           s_tdata[CPU_W +: ADDR_W]));
        n_req <= n_req + 1;
      end
    end
  end

endmodule

@@ bench/tb_per_cpu_page_allocator.sv @@
// Testbench top for the page allocator: request and config stimulus, result sink, verdict.
module tb_per_cpu_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import pcpa_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 290;
  localparam int PAD_W       = IN_DATA_W - CPU_W - ADDR_W;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [ADDR_W-1:0]     cfg_data  = '0;

  int n_req;
  int n_res;
  int errors;
  int cycles    = 0;
  int n_windows = 1;
  bit burst     = 1'b0;

  // window as last written, used only to aim free addresses
  logic [ADDR_W-1:0] cur_low = 32'h8000_0000;
  logic [ADDR_W-1:0] cur_top = 32'h8800_0000;

  per_cpu_page_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // cpu[2:0], page_address[34:3], zero pad above
    .s_tuser   (s_tuser),   // func[0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // status[1:0], granted_address[33:2], source_cpu[36:34]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcpa_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .n_req     (n_req),
    .n_res     (n_res),
    .errors    (errors)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, n_req - n_res);
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(func_t fn, logic [CPU_W-1:0] cpu, logic [ADDR_W-1:0] addr);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {{PAD_W{1'b0}}, addr, cpu};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait until every result beat has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (n_req != n_res);
  endtask

  task automatic set_window(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_LOWEST;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_TOP;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_low = lo;
    cur_top = hi;
    n_windows++;
  endtask

  // mostly aligned pages inside the window, the rest misaligned, outside or random
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    longint unsigned base;
    longint unsigned pages;
    longint unsigned slot;
    longint unsigned a;
    int              r;
    base = 64'(cur_low);
    base = ((base + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    r    = $urandom_range(0, 99);
    if (base >= cur_top || r >= 92) return $urandom();
    pages = (cur_top - base + PAGE_BYTES - 1) / PAGE_BYTES;
    if (pages > NUM_PAGES + 16) pages = NUM_PAGES + 16;  // reach just past the slot range
    if (r < 10) slot = 64'($urandom_range(0, (pages < 32 ? pages : 32) - 1));
    else if (r < 15) slot = pages - 1;
    else slot = 64'($urandom_range(0, pages - 1));
    a = base + slot * PAGE_BYTES;
    if (r >= 70 && r < 80) begin
      a = a + $urandom_range(1, PAGE_BYTES - 1);
    end else if (r >= 80 && r < 86) begin
      a = base - PAGE_BYTES * $urandom_range(1, 4);
    end else if (r >= 86) begin
      a = 64'(cur_top);
      a = ((a + PAGE_BYTES - 1) / PAGE_BYTES + $urandom_range(0, 3)) * PAGE_BYTES;
    end
    return a[ADDR_W-1:0];
  endfunction

  task automatic random_phase(int count, int alloc_pct);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < alloc_pct)
        send_request(FN_ALLOC, CPU_W'($urandom_range(0, NUM_CPUS - 1)), $urandom());
      else
        send_request(FN_FREE, CPU_W'($urandom_range(0, NUM_CPUS - 1)), pick_free_addr());
    end
    burst = 1'b0;
  endtask

  // result sink: random ready gaps, plus one long hold-off once enough requests went in
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && n_req >= HOLD_AT) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default window: accepted, misaligned, below, at top, last page, far out
    send_request(FN_FREE, 0, 32'h8000_0000);
    send_request(FN_FREE, 0, 32'h8000_1000);
    send_request(FN_FREE, 0, 32'h8000_0800);
    send_request(FN_FREE, 1, 32'h7FFF_F000);
    send_request(FN_FREE, 1, 32'h8800_0000);
    send_request(FN_FREE, 7, 32'h87FF_F000);
    send_request(FN_FREE, 2, 32'h0000_0000);
    send_request(FN_FREE, 2, 32'hFFFF_FFFF);
    // own list, then stealing from cpu 0 and cpu 7, then empty
    send_request(FN_ALLOC, 0, 32'h0000_0000);
    send_request(FN_ALLOC, 5, 32'h0000_0000);
    send_request(FN_ALLOC, 5, 32'hFFFF_FFFF);
    send_request(FN_ALLOC, 3, 32'h0000_0000);
    send_request(FN_ALLOC, 7, 32'hFFFF_FFFF);
    drain();

    random_phase(250, 45);
    random_phase(60, 50);

    // full address space: slot range overflow, old pages seen at the new base
    set_window(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(FN_FREE, 1, 32'h0800_0000);
    send_request(FN_FREE, 1, 32'h07FF_F000);
    send_request(FN_FREE, 6, 32'h0000_0000);
    send_request(FN_ALLOC, 6, 32'h0000_0000);
    send_request(FN_ALLOC, 1, 32'h0000_0000);
    send_request(FN_ALLOC, 4, 32'h0000_0000);
    random_phase(200, 50);

    // unaligned lower bound rounds the base up; then a double free
    set_window(32'h0001_2345, 32'h0005_2345);
    send_request(FN_FREE, 3, 32'h0001_2000);
    send_request(FN_FREE, 3, 32'h0001_3000);
    send_request(FN_FREE, 4, 32'h0005_2000);
    send_request(FN_FREE, 4, 32'h0005_2000);
    send_request(FN_ALLOC, 4, 32'h0000_0000);
    send_request(FN_ALLOC, 4, 32'h0000_0000);
    random_phase(150, 50);

    set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(40, 50);
    set_window(32'h0000_0000, 32'h0000_0000);
    random_phase(30, 50);
    set_window(32'hF000_0000, 32'hFFFF_FFFF);
    random_phase(150, 40);
    set_window(32'h8000_0000, 32'h8800_0000);
    random_phase(100, 50);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d result beats, %0d address windows", n_req, n_res,
             n_windows);
    $display("incl. rejects, stealing, out-of-memory, double free and a long output stall");
    if (errors == 0 && n_req == n_res)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/pcpa_pkg.sv
hdl/pcpa_alu.sv
hdl/pcpa_link_mem.sv
hdl/per_cpu_page_allocator.sv
bench/pcpa_checker.sv
bench/tb_per_cpu_page_allocator.sv
